// ===== design/stbe_pkg.sv =====
// Shared types and constants for the sprite tween and blink engine.
// No dependencies; stbe_lane and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package stbe_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_DURATION   = 3'd0;
  localparam logic [2:0] CFG_START_X    = 3'd1;
  localparam logic [2:0] CFG_END_X      = 3'd2;
  localparam logic [2:0] CFG_START_Y    = 3'd3;
  localparam logic [2:0] CFG_END_Y      = 3'd4;
  localparam logic [2:0] CFG_TOP_NIBBLE = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Blink counter limits
  localparam logic [4:0] BLINK_SHOW_MAX = 5'd13;
  localparam logic [4:0] BLINK_WRAP     = 5'd19;

  // Position word assembly
  localparam logic [16:0] POS_BIAS    = 17'd8;
  localparam logic [31:0] POS_MARKER  = 32'h4000_0000;
  localparam logic [10:0] TILE_MARKER = 11'h400;

  // Serial multiply / divide lengths
  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_MUL,
    LN_DIV,
    LN_ADD
  } lane_phase_t;

  // Launch command shared by both axis lanes
  typedef struct packed {
    logic        go;
    logic        step_neg;
    logic [15:0] step_mag;
  } lane_req_t;

endpackage

`default_nettype wire

// ===== design/stbe_if.sv =====
// Valid/ready channel interfaces for tick items and result items.
// Depends on nothing; used by the top level ports.
`timescale 1ns / 1ps
`default_nettype none

interface stbe_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] tile_source;
  logic        start_motion;

  modport source (output valid, output tile_source, output start_motion, input ready);
  modport sink   (input valid, input tile_source, input start_motion, output ready);
endinterface

interface stbe_out_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic        [31:0] position_word;
  logic        [10:0] tile_word;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, output visible, output position_word, output tile_word,
                  output pos_x, output pos_y, input ready);
  modport sink   (input valid, input visible, input position_word, input tile_word,
                  input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// ===== design/stbe_lane.sv =====
// One axis of the tween: start + (step*(end-start))/duration, wrapped to 16 bits.
// Bit-serial shift-add multiply then restoring divide; depends on stbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stbe_lane (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire stbe_pkg::lane_req_t     req,
  input  wire logic signed [15:0]      start_val,
  input  wire logic signed [15:0]      end_val,
  input  wire logic        [14:0]      dur,
  output logic signed      [15:0]      result,
  output logic                         done
);
  import stbe_pkg::*;

  lane_phase_t        phase;
  lane_phase_t        phase_next;
  logic        [4:0]  cnt;
  logic        [31:0] prod;
  logic        [15:0] mcand;
  logic        [14:0] rem;
  logic        [14:0] dur_r;
  logic signed [15:0] base;
  logic               neg;

  logic signed [16:0] diff;
  logic        [15:0] diff_mag;
  logic        [16:0] mul_sum;
  logic        [15:0] trial;
  logic               fits;
  logic        [15:0] quot;

  assign diff     = {end_val[15], end_val} - {start_val[15], start_val};
  assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
  assign mul_sum  = {1'b0, prod[31:16]} + {1'b0, (prod[0] ? mcand : 16'd0)};
  assign trial    = {rem, prod[31]};
  assign fits     = trial >= {1'b0, dur_r};
  assign quot     = neg ? 16'(-prod[15:0]) : prod[15:0];
  assign result   = base + $signed(quot);
  assign done     = (phase == LN_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= LN_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      LN_IDLE: if (req.go) phase_next = LN_MUL;
      LN_MUL:  if (cnt == 5'(MUL_STEPS - 1)) phase_next = LN_DIV;
      LN_DIV:  if (cnt == 5'(DIV_STEPS - 1)) phase_next = LN_ADD;
      LN_ADD:  phase_next = LN_IDLE;
      default: phase_next = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      LN_IDLE: begin
        if (req.go) begin
          prod  <= {16'd0, req.step_mag};
          mcand <= diff_mag;
          neg   <= diff[16] ^ req.step_neg;
          base  <= start_val;
          dur_r <= dur;
          rem   <= '0;
          cnt   <= '0;
        end
      end
      LN_MUL: begin
        // accumulate high half, retire one multiplier bit
        prod <= {mul_sum, prod[15:1]};
        cnt  <= (cnt == 5'(MUL_STEPS - 1)) ? 5'd0 : cnt + 5'd1;
      end
      LN_DIV: begin
        // one quotient bit per cycle shifts in at the bottom
        rem  <= fits ? 15'(trial - {1'b0, dur_r}) : trial[14:0];
        prod <= {prod[30:0], fits};
        cnt  <= cnt + 5'd1;
      end
      LN_ADD: begin
        cnt <= '0;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sprite_tween_blink_engine_top.sv =====
// Sprite tween and blink engine: one tick item in, one result item out.
// Depends on stbe_pkg, stbe_if and stbe_lane.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted tick yields exactly one result. A tick with no motion step
// goes straight to the emit step, which loads its result into the output
// register; the next tick is taken once the engine returns to idle. A tick
// that advances the motion runs both axes in parallel through a bit-serial
// lane: shift-add multiply, restoring divide, the final add, and then the
// load of the output register. No new tick is taken until the result has
// been loaded and the engine is back in idle.
// The output register holds a result until the sink takes it; a finished
// tick waits in the emit step while that register is full and not being taken,
// and the next accept waits with it.
// Configuration registers reset to zero and are written through cfg_we,
// cfg_index and cfg_wdata; writes to indexes past the top nibble are ignored.
module sprite_tween_blink_engine_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  stbe_in_if.sink                                 in_item,
  stbe_out_if.source                              out_item,
  input  wire logic                               cfg_we,
  input  wire logic [stbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [stbe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import stbe_pkg::*;

  // configuration
  logic        [14:0] duration;
  logic signed [15:0] start_x;
  logic signed [15:0] end_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_y;
  logic        [3:0]  top_nibble;

  // engine state
  eng_state_t         state;
  eng_state_t         state_next;
  logic        [15:0] step_count;
  logic               motion_active;
  logic        [4:0]  blink_count;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic               moved;
  logic        [10:0] tile_hi;

  // output register
  logic               out_valid;
  logic               out_visible;
  logic        [31:0] out_pw;
  logic        [10:0] out_tile;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;

  logic               accept;
  logic               emit;
  logic        [15:0] step_base;
  logic               active_base;
  logic               do_step;
  logic        [15:0] step_new;
  lane_req_t          lane_req;
  logic signed [15:0] lane_x;
  logic signed [15:0] lane_y;
  logic               lane_done;
  logic               lane_y_done;
  logic        [4:0]  blink_inc;
  logic        [16:0] x_bias;
  logic        [15:0] y_bias;
  logic        [31:0] pos_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration   <= '0;
      start_x    <= '0;
      end_x      <= '0;
      start_y    <= '0;
      end_y      <= '0;
      top_nibble <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DURATION:   duration   <= cfg_wdata[14:0];
        CFG_START_X:    start_x    <= cfg_wdata;
        CFG_END_X:      end_x      <= cfg_wdata;
        CFG_START_Y:    start_y    <= cfg_wdata;
        CFG_END_Y:      end_y      <= cfg_wdata;
        CFG_TOP_NIBBLE: top_nibble <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // motion bookkeeping at accept
  assign step_base   = in_item.start_motion ? 16'd0 : step_count;
  assign active_base = in_item.start_motion ? (duration != 15'd0) : motion_active;
  assign do_step     = active_base && (duration != 15'd0);
  assign step_new    = step_base + 16'd1;

  assign lane_req.step_neg = step_new[15];
  assign lane_req.step_mag = step_new[15] ? 16'(-step_new) : step_new;
  assign lane_req.go       = accept && do_step;

  stbe_lane u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .req       (lane_req),
    .start_val (start_x),
    .end_val   (end_x),
    .dur       (duration),
    .result    (lane_x),
    .done      (lane_done)
  );

  stbe_lane u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .req       (lane_req),
    .start_val (start_y),
    .end_val   (end_y),
    .dur       (duration),
    .result    (lane_y),
    .done      (lane_y_done)
  );

  // result assembly
  assign blink_inc = (moved ? 5'd0 : blink_count) + 5'd1;
  assign x_bias    = {cur_x[15], cur_x} - POS_BIAS;
  assign y_bias    = cur_y - POS_BIAS[15:0];
  assign pos_word  = {{15{x_bias[16]}}, x_bias} | {y_bias, 16'd0} | POS_MARKER
                   | {top_nibble, 28'd0};

  assign in_item.ready          = (state == ST_IDLE);
  assign out_item.valid         = out_valid;
  assign out_item.visible       = out_visible;
  assign out_item.position_word = out_pw;
  assign out_item.tile_word     = out_tile;
  assign out_item.pos_x         = out_x;
  assign out_item.pos_y         = out_y;

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        accept = in_item.valid;
        if (in_item.valid) state_next = do_step ? ST_CALC : ST_EMIT;
      end
      ST_CALC: begin
        if (lane_done && lane_y_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        emit = !out_valid || out_item.ready;
        if (emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step_count    <= '0;
      motion_active <= 1'b0;
      blink_count   <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      moved         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        moved <= do_step;
        if (do_step) begin
          step_count    <= step_new;
          motion_active <= !($signed(step_new) >= $signed({1'b0, duration}));
        end else begin
          step_count    <= step_base;
          motion_active <= 1'b0;
        end
      end
      if (state == ST_CALC && lane_done && lane_y_done) begin
        cur_x <= lane_x;
        cur_y <= lane_y;
      end
      if (emit) begin
        blink_count <= (blink_inc > BLINK_WRAP) ? 5'd0 : blink_inc;
        out_valid   <= 1'b1;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tile_hi <= in_item.tile_source[15:5];
    end
    if (emit) begin
      out_visible <= (blink_inc <= BLINK_SHOW_MAX);
      out_pw      <= pos_word;
      out_tile    <= tile_hi | TILE_MARKER;
      out_x       <= cur_x;
      out_y       <= cur_y;
    end
  end

endmodule

`default_nettype wire
